// File: hdl/smtw_pkg.sv
// ----------------------------------------------------------------------------
// smtw_pkg
// shared types and constants of the tick-paced spi transmit waveform unit
// ----------------------------------------------------------------------------
package smtw_pkg;

   // waveform shape
   localparam int unsigned HEAD_TICKS    = 2;
   localparam int unsigned MAX_WORD_BITS = 32;

   // field widths
   localparam int unsigned DATA_W   = 32;
   localparam int unsigned WLEN_W   = 6;
   localparam int unsigned SLOT_W   = 8;
   localparam int unsigned BITSEL_W = 5;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 8;

   typedef logic [DATA_W-1:0]     data_type;
   typedef logic [WLEN_W-1:0]     wlen_type;
   typedef logic [SLOT_W-1:0]     slot_type;
   typedef logic [BITSEL_W-1:0]   bitsel_type;
   typedef logic [CSR_IDX_W-1:0]  csr_idx_type;
   typedef logic [CSR_DATA_W-1:0] csr_data_type;

   // request modes
   typedef enum logic {
      MODE_START = 1'b0,
      MODE_TICK  = 1'b1
   } mode_type;

   // register indexes
   localparam csr_idx_type CSR_WORD_LENGTH    = 2'd0;
   localparam csr_idx_type CSR_CLOCK_PHASE    = 2'd1;
   localparam csr_idx_type CSR_CLOCK_POLARITY = 2'd2;

endpackage

// File: hdl/smtw_req_if.sv
// ----------------------------------------------------------------------------
// smtw_req_if
// request channel: start or tick, with the word to send
// ----------------------------------------------------------------------------
interface smtw_req_if;
   logic                valid;
   logic                ready;
   logic                mode;
   smtw_pkg::data_type  data;

   modport source (output valid, output mode, output data, input ready);
   modport sink   (input valid, input mode, input data, output ready);
endinterface

// File: hdl/smtw_rsp_if.sv
// ----------------------------------------------------------------------------
// smtw_rsp_if
// response channel: start status and pin levels after each request
// ----------------------------------------------------------------------------
interface smtw_rsp_if;
   logic valid;
   logic ready;
   logic accepted;
   logic active;
   logic cs_level;
   logic clk_level;
   logic mosi_level;

   modport source (output valid, output accepted, output active, output cs_level,
                   output clk_level, output mosi_level, input ready);
   modport sink   (input valid, input accepted, input active, input cs_level,
                   input clk_level, input mosi_level, output ready);
endinterface

// File: hdl/smtw_csr_if.sv
// ----------------------------------------------------------------------------
// smtw_csr_if
// register write channel: index and write data
// ----------------------------------------------------------------------------
interface smtw_csr_if;
   logic                    valid;
   logic                    ready;
   smtw_pkg::csr_idx_type   index;
   smtw_pkg::csr_data_type  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// File: hdl/spi_master_tick_waveform_unit.sv
// ----------------------------------------------------------------------------
// spi_master_tick_waveform_unit
// transmit-only spi master whose pin waveform advances one slot per tick
// ----------------------------------------------------------------------------
//
//   channel  | direction | contents
//   ---------+-----------+-----------------------------------------------
//   req_if   | in        | mode (start / tick), data word
//   rsp_if   | out       | accepted, active, cs, clk and mosi levels
//   csr_if   | in        | register index, write data
//
// every request passes through the input register, then through the slot decode
// into the response register, before its earliest response handshake. a new
// request is taken every cycle; the only limit is the response register, which
// frees as the sink takes it.
// reset clears the transfer state but for the shift word, the registers and both
// valid stages; chip select comes out of reset high. a stalled response holds the input
// stage, and req_if.ready falls only when both stages are full.
// register writes are always taken and are dropped while a transfer runs.
//
module spi_master_tick_waveform_unit (
   input  logic          clock,
   input  logic          reset,
   smtw_req_if.sink      req_if,
   smtw_rsp_if.source    rsp_if,
   smtw_csr_if.sink      csr_if
);
   import smtw_pkg::*;

   // configuration registers
   wlen_type   word_length_ff;
   logic       clock_phase_ff;
   logic       clock_polarity_ff;

   // transfer state
   data_type   shift_word_ff,  shift_word_in;
   slot_type   slot_index_ff,  slot_index_in;
   logic       busy_ff,        busy_in;
   logic       cs_pin_ff,      cs_pin_in;
   logic       clk_pin_ff,     clk_pin_in;
   logic       mosi_pin_ff,    mosi_pin_in;

   // input stage
   logic       s1_valid_ff;
   logic       s1_mode_ff;
   data_type   s1_data_ff;

   // response stage
   logic       rsp_valid_ff;
   logic       rsp_accepted_ff, accepted_in;
   logic       rsp_active_ff;
   logic       rsp_cs_ff;
   logic       rsp_clk_ff;
   logic       rsp_mosi_ff;

   logic       out_free;
   logic       s1_fire;
   logic       req_fire;

   // slot decode
   slot_type   total_slots;
   slot_type   data_slot;
   slot_type   mosi_slot;
   wlen_type   bit_count;
   wlen_type   bit_pos;
   logic       start_ok;
   logic       idle_level;

   // handshakes: the response register parts the two sides
   assign out_free  = !rsp_valid_ff || rsp_if.ready;
   assign s1_fire   = s1_valid_ff && out_free;
   assign req_if.ready = !s1_valid_ff || out_free;
   assign req_fire  = req_if.valid && req_if.ready;
   assign csr_if.ready = 1'b1;

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.accepted   = rsp_accepted_ff;
   assign rsp_if.active     = rsp_active_ff;
   assign rsp_if.cs_level   = rsp_cs_ff;
   assign rsp_if.clk_level  = rsp_clk_ff;
   assign rsp_if.mosi_level = rsp_mosi_ff;

   // word length never exceeds MAX_WORD_BITS while busy, so the sum fits
   assign total_slots = SLOT_W'(HEAD_TICKS) + {word_length_ff, 2'b00};
   assign idle_level  = clock_polarity_ff;
   assign start_ok    = !busy_ff && (word_length_ff != '0)
                        && (word_length_ff <= WLEN_W'(MAX_WORD_BITS));
   assign data_slot   = slot_index_ff - SLOT_W'(HEAD_TICKS);
   // phase 1 holds mosi two slots behind the clock
   assign mosi_slot   = clock_phase_ff ? (data_slot - SLOT_W'(2)) : data_slot;
   assign bit_count   = mosi_slot[SLOT_W-1:2];
   assign bit_pos     = word_length_ff - WLEN_W'(1) - bit_count;

   always_comb begin
      shift_word_in = shift_word_ff;
      slot_index_in = slot_index_ff;
      busy_in       = busy_ff;
      cs_pin_in     = cs_pin_ff;
      clk_pin_in    = clk_pin_ff;
      mosi_pin_in   = mosi_pin_ff;
      accepted_in   = 1'b0;
      if (s1_mode_ff == MODE_START) begin
         if (start_ok) begin
            shift_word_in = s1_data_ff;
            slot_index_in = '0;
            busy_in       = 1'b1;
            accepted_in   = 1'b1;
         end
      end else if (busy_ff) begin
         if (slot_index_ff >= total_slots) begin
            // tick after the last slot closes the transfer, pins hold
            busy_in = 1'b0;
         end else begin
            slot_index_in = slot_index_ff + SLOT_W'(1);
            if (slot_index_ff < SLOT_W'(HEAD_TICKS)) begin
               // head: chip select still high, clock idle
               cs_pin_in   = 1'b1;
               clk_pin_in  = idle_level;
               mosi_pin_in = 1'b0;
            end else begin
               // clock active on the middle two slots of each bit
               clk_pin_in = ((data_slot[1:0] == 2'd1) || (data_slot[1:0] == 2'd2))
                            ? ~idle_level : idle_level;
               cs_pin_in  = (slot_index_ff + SLOT_W'(1) == total_slots);
               if (clock_phase_ff && (data_slot < SLOT_W'(2))) begin
                  mosi_pin_in = 1'b0;
               end else if ({2'b00, bit_count} < {2'b00, word_length_ff}) begin
                  mosi_pin_in = shift_word_ff[bit_pos[BITSEL_W-1:0]];
               end else begin
                  mosi_pin_in = 1'b0;
               end
            end
         end
      end
   end

   // configuration: taken only between transfers
   always_ff @(posedge clock) begin
      if (reset) begin
         word_length_ff    <= '0;
         clock_phase_ff    <= 1'b0;
         clock_polarity_ff <= 1'b0;
      end else if (csr_if.valid && !busy_ff) begin
         unique case (csr_if.index)
            CSR_WORD_LENGTH:    word_length_ff    <= csr_if.data[WLEN_W-1:0];
            CSR_CLOCK_PHASE:    clock_phase_ff    <= csr_if.data[0];
            CSR_CLOCK_POLARITY: clock_polarity_ff <= csr_if.data[0];
            default: ;
         endcase
      end
   end

   // transfer state, advanced once per request leaving the input stage
   always_ff @(posedge clock) begin
      if (reset) begin
         slot_index_ff <= '0;
         busy_ff       <= 1'b0;
         cs_pin_ff     <= 1'b1;
         clk_pin_ff    <= 1'b0;
         mosi_pin_ff   <= 1'b0;
      end else if (s1_fire) begin
         slot_index_ff <= slot_index_in;
         busy_ff       <= busy_in;
         cs_pin_ff     <= cs_pin_in;
         clk_pin_ff    <= clk_pin_in;
         mosi_pin_ff   <= mosi_pin_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire) begin
         shift_word_ff <= shift_word_in;
      end
   end

   // input stage
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_if.ready) begin
         s1_valid_ff <= req_if.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_mode_ff <= req_if.mode;
         s1_data_ff <= req_if.data;
      end
   end

   // response stage
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire) begin
         rsp_accepted_ff <= accepted_in;
         rsp_active_ff   <= busy_in;
         rsp_cs_ff       <= cs_pin_in;
         rsp_clk_ff      <= clk_pin_in;
         rsp_mosi_ff     <= mosi_pin_in;
      end
   end

`ifndef ASSERT_OFF
   // a running transfer always has a legal word length
   assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (word_length_ff != '0) && (word_length_ff <= WLEN_W'(MAX_WORD_BITS)))
      else $error("busy with illegal word length");

   // the slot counter never runs past the end of the waveform
   assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (slot_index_ff <= total_slots))
      else $error("slot index beyond waveform");

   // an accepted start leaves the transfer running
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_accepted_ff) |-> rsp_active_ff)
      else $error("accepted start not active");

   // an accepted start restarts the slot count
   assert property (@(posedge clock) disable iff (reset)
      (s1_fire && accepted_in) |=> (busy_ff && (slot_index_ff == '0)))
      else $error("start did not arm transfer");

   // pins hold while idle
   assert property (@(posedge clock) disable iff (reset)
      (!busy_ff && !s1_fire) |=> ($stable(cs_pin_ff) && $stable(clk_pin_ff)
                                  && $stable(mosi_pin_ff)))
      else $error("pins moved while idle");
`endif

endmodule

// File: dv/spi_master_tick_waveform_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spi_master_tick_waveform_unit_test
// self-checking bench for the tick-paced spi transmit waveform unit. start and
// tick requests go in with random gaps while the response side stalls at
// random; a pin tracker mirrors the transfer state and the registers, works
// out the expected status and pin levels of every accepted request and checks
// each response against them in order. registers change only between phases,
// once every outstanding response has come back.
// ----------------------------------------------------------------------------
module spi_master_tick_waveform_unit_test;
   import smtw_pkg::*;

   // cycles to let the two-stage pipe drain before touching the registers
   localparam int unsigned SETTLE_CYCLES = 4;
   // transfer requests (accepted starts and ticks during a transfer) to aim for
   localparam int unsigned WAVE_TARGET   = 1450;
   // the one index the block does not decode
   localparam csr_idx_type CSR_UNUSED    = 2'd3;

   typedef struct packed {
      logic accepted;
      logic active;
      logic cs_level;
      logic clk_level;
      logic mosi_level;
   } pins_type;

   // mirror of the transfer state, the registers and the pins; holds the
   // responses still owed by the block
   class pin_tracker;
      wlen_type    wlen;
      logic        cpha;
      logic        cpol;
      data_type    tx_word;
      slot_type    slot_no;
      logic        in_transfer;
      logic        cs_now;
      logic        clk_now;
      logic        mosi_now;
      pins_type    expected_pins[$];
      int unsigned mismatches;

      function new();
         wlen        = '0;
         cpha        = 1'b0;
         cpol        = 1'b0;
         tx_word     = '0;
         slot_no     = '0;
         in_transfer = 1'b0;
         cs_now      = 1'b1;
         clk_now     = 1'b0;
         mosi_now    = 1'b0;
         mismatches  = 0;
      endfunction

      task report(string what);
         mismatches++;
         $display("mismatch at %0t ns: %s", $time, what);
      endtask

      function void write_register(csr_idx_type idx, csr_data_type value);
         if (in_transfer)
            return;
         case (idx)
            CSR_WORD_LENGTH:    wlen = value[WLEN_W-1:0];
            CSR_CLOCK_PHASE:    cpha = value[0];
            CSR_CLOCK_POLARITY: cpol = value[0];
            default: ;
         endcase
      endfunction

      // pin levels of one slot: head, then four slots per bit
      function void levels_for_slot(int slot);
         int total;
         int d;
         int e;
         int k;
         total = HEAD_TICKS + 4 * wlen;
         if (slot < HEAD_TICKS) begin
            cs_now   = 1'b1;
            clk_now  = cpol;
            mosi_now = 1'b0;
         end else begin
            d        = slot - HEAD_TICKS;
            clk_now  = (d % 4 == 1 || d % 4 == 2) ? ~cpol : cpol;
            cs_now   = (slot + 1 == total);
            e        = cpha ? d - 2 : d;
            k        = e / 4;
            if (e < 0 || k >= wlen)
               mosi_now = 1'b0;
            else
               mosi_now = tx_word[wlen - 1 - k];
         end
      endfunction

      // returns 1 when the request does real work on the waveform
      function logic note_request(mode_type mode, data_type data);
         logic took;
         logic moved;
         int   total;
         took  = 1'b0;
         moved = 1'b0;
         if (mode == MODE_START) begin
            if (!in_transfer && wlen != 0 && wlen <= MAX_WORD_BITS) begin
               tx_word     = data;
               slot_no     = '0;
               in_transfer = 1'b1;
               took        = 1'b1;
               moved       = 1'b1;
            end
         end else if (in_transfer) begin
            moved = 1'b1;
            total = HEAD_TICKS + 4 * wlen;
            if (slot_no >= total) begin
               in_transfer = 1'b0;
            end else begin
               levels_for_slot(slot_no);
               slot_no = slot_no + 1'b1;
            end
         end
         expected_pins.push_back('{took, in_transfer, cs_now, clk_now, mosi_now});
         return moved;
      endfunction

      task compare_level(string name, logic got, logic want);
         if (got !== want)
            report($sformatf("%s is %b, expected %b", name, got, want));
      endtask

      task check_pins(pins_type got);
         pins_type want;
         if (expected_pins.size() == 0) begin
            report($sformatf("response %b with no request outstanding", got));
            return;
         end
         want = expected_pins.pop_front();
         compare_level("accepted", got.accepted, want.accepted);
         compare_level("active", got.active, want.active);
         compare_level("cs_level", got.cs_level, want.cs_level);
         compare_level("clk_level", got.clk_level, want.clk_level);
         compare_level("mosi_level", got.mosi_level, want.mosi_level);
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        calm  = 1'b0;    // phase with no gaps and no stalls
   int unsigned stall_left = 0;
   int unsigned wave_items = 0;
   pin_tracker  tracker = new();

   smtw_req_if req_ch ();
   smtw_rsp_if rsp_ch ();
   smtw_csr_if csr_ch ();

   spi_master_tick_waveform_unit i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch),
      .csr_if (csr_ch)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // mostly no gap, often a short one, now and then a long one
   function automatic int unsigned gap_length();
      int unsigned r;
      if (calm)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      else if (r < 90)
         return $urandom_range(1, 3);
      else
         return $urandom_range(4, 20);
   endfunction

   // response side: ready for a cycle, then a random stall
   always @(posedge clock) begin
      if (stall_left != 0) begin
         rsp_ch.ready <= 1'b0;
         stall_left   <= stall_left - 1;
      end else begin
         rsp_ch.ready <= 1'b1;
         stall_left   <= gap_length();
      end
   end

   // every response taken is checked against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         tracker.check_pins('{rsp_ch.accepted, rsp_ch.active, rsp_ch.cs_level,
                              rsp_ch.clk_level, rsp_ch.mosi_level});
   end

   // one request, after a random gap; valid stays up for a following request
   task automatic push_request(mode_type mode, data_type data);
      int unsigned gap;
      gap = gap_length();
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.mode  <= mode;
      req_ch.data  <= data;
      do @(posedge clock); while (!req_ch.ready);
      if (tracker.note_request(mode, data))
         wave_items++;
   endtask

   // ticks until the transfer ends, with the odd start thrown in while busy
   task automatic finish_transfer(logic with_noise);
      while (tracker.in_transfer) begin
         if (with_noise && $urandom_range(0, 29) == 0)
            push_request(MODE_START, $urandom);
         else
            push_request(MODE_TICK, $urandom);
      end
   endtask

   task automatic send_word(data_type word);
      push_request(MODE_START, word);
      finish_transfer(1'b1);
   endtask

   // stop requests and wait for every response, then for the pipe to empty
   task automatic settle();
      req_ch.valid <= 1'b0;
      while (tracker.expected_pins.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(csr_idx_type idx, csr_data_type value);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= value;
      do @(posedge clock); while (!csr_ch.ready);
      tracker.write_register(idx, value);
      csr_ch.valid <= 1'b0;
      @(posedge clock);
   endtask

   // new settings for a phase; the unused upper bits carry junk
   task automatic set_up(int unsigned wl, logic phase, logic polarity);
      settle();
      write_reg(CSR_WORD_LENGTH, {2'($urandom_range(0, 3)), wlen_type'(wl)});
      write_reg(CSR_CLOCK_PHASE, {7'($urandom_range(0, 127)), phase});
      write_reg(CSR_CLOCK_POLARITY, {7'($urandom_range(0, 127)), polarity});
   endtask

   initial begin
      int unsigned pick;
      int unsigned wl;
      logic        first_phase;

      req_ch.valid = 1'b0;
      req_ch.mode  = MODE_TICK;
      req_ch.data  = '0;
      rsp_ch.ready = 1'b0;
      csr_ch.valid = 1'b0;
      csr_ch.index = CSR_WORD_LENGTH;
      csr_ch.data  = '0;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // --- directed part ---
      calm <= 1'b1;
      // out of reset the word length is zero: start refused, tick does nothing
      push_request(MODE_START, '1);
      push_request(MODE_TICK, '0);

      // one-bit word, phase 0, polarity 0, with a start refused while busy
      set_up(1, 1'b0, 1'b0);
      push_request(MODE_START, 32'h0000_0001);
      push_request(MODE_START, '0);
      finish_transfer(1'b0);

      // unused register index, then word lengths above the maximum
      settle();
      write_reg(CSR_UNUSED, '1);
      set_up(33, 1'b0, 1'b0);
      push_request(MODE_START, '1);
      set_up(63, 1'b1, 1'b1);
      push_request(MODE_START, '1);

      // two-bit word, delayed data, clock idling high
      set_up(2, 1'b1, 1'b1);
      push_request(MODE_START, 32'hFFFF_FFFE);
      finish_transfer(1'b0);

      // --- random part: phases of a few transfers under one setting ---
      wave_items  = 0;
      first_phase = 1'b1;
      while (wave_items < WAVE_TARGET) begin
         settle();
         calm <= ($urandom_range(0, 4) == 0);
         if (first_phase) begin
            // longest word with both modes flipped, right away
            set_up(MAX_WORD_BITS, 1'b1, 1'b1);
            first_phase = 1'b0;
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 6)
               wl = 0;
            else if (pick < 10)
               wl = $urandom_range(MAX_WORD_BITS + 1, 63);
            else if (pick < 18)
               wl = MAX_WORD_BITS;
            else if (pick < 30)
               wl = $urandom_range(9, MAX_WORD_BITS - 1);
            else
               wl = $urandom_range(1, 8);
            set_up(wl, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
         end
         if ($urandom_range(0, 7) == 0)
            write_reg(CSR_UNUSED, csr_data_type'($urandom));
         repeat ($urandom_range(1, 4)) begin
            // a stray tick between transfers
            if ($urandom_range(0, 9) == 0)
               push_request(MODE_TICK, $urandom);
            send_word($urandom);
         end
      end

      // drain and let the pipe run dry before the verdict
      settle();
      repeat (8) @(posedge clock);
      if (tracker.expected_pins.size() != 0)
         tracker.report($sformatf("%0d responses never arrived",
                                  tracker.expected_pins.size()));
      if (tracker.mismatches == 0)
         $display("spi_master_tick_waveform_unit regression: pass");
      else
         $display("spi_master_tick_waveform_unit regression: fail");
      $finish;
   end

   // watchdog, well above the slowest correct run
   initial begin
      #5_000_000;
      $display("spi_master_tick_waveform_unit regression: fail");
      $finish;
   end

endmodule
